/* rtl/mqsd_pkg.sv */
// -----------------------------------------------------------------------------
// mqsd_pkg
// Types, constants and helper functions for the multiquadratic squared
// distance test: payload structs, register map and basis root weights.
// -----------------------------------------------------------------------------
package mqsd_pkg;

   // Field sizes
   localparam int NUM_COMPONENTS = 8;
   localparam int COEF_BITS_DEF  = 8;
   localparam int COMP_IDX_W     = 3;
   localparam int PACKED_W       = 64;
   localparam int ACC_W          = 32;
   localparam int WEIGHT_W       = 13;   // signed width of a doubled root weight
   localparam int CHECK_W        = 4;

   // Configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Register indexes (byte address bit 2)
   localparam logic REG_TARGET  = 1'b0;
   localparam logic REG_CHECKED = 1'b1;

   // Register reset values
   localparam logic [ACC_W-1:0]   TARGET_RESET  = 32'd3600;
   localparam logic [CHECK_W-1:0] CHECKED_RESET = 4'd4;
   localparam logic [CHECK_W-1:0] CHECKED_MIN   = 4'd1;
   localparam logic [CHECK_W-1:0] CHECKED_MAX   = 4'd8;

   typedef struct packed {
      logic [PACKED_W-1:0] a_x_packed;
      logic [PACKED_W-1:0] a_y_packed;
      logic [PACKED_W-1:0] b_x_packed;
      logic [PACKED_W-1:0] b_y_packed;
   } req_payload_type;

   typedef struct packed {
      logic signed [ACC_W-1:0] sq_comp0;
      logic signed [ACC_W-1:0] sq_comp1;
      logic signed [ACC_W-1:0] sq_comp2;
      logic signed [ACC_W-1:0] sq_comp3;
      logic signed [ACC_W-1:0] sq_comp4;
      logic signed [ACC_W-1:0] sq_comp5;
      logic signed [ACC_W-1:0] sq_comp6;
      logic signed [ACC_W-1:0] sq_comp7;
      logic                    is_match;
   } rsp_payload_type;

   // Square root under each basis element: 1,3,11,33,35,105,385,1155
   function automatic logic [WEIGHT_W-2:0] root_weight(input logic [COMP_IDX_W-1:0] idx);
      logic [WEIGHT_W-2:0] w;
      case (idx)
         3'd0:    w = 12'd1;
         3'd1:    w = 12'd3;
         3'd2:    w = 12'd11;
         3'd3:    w = 12'd33;
         3'd4:    w = 12'd35;
         3'd5:    w = 12'd105;
         3'd6:    w = 12'd385;
         default: w = 12'd1155;
      endcase
      return w;
   endfunction

   // Weight of the pair (k, k^m) in component m; off-diagonal pairs count twice
   function automatic logic [WEIGHT_W-2:0] term_weight(input int m, input int k);
      logic [WEIGHT_W-2:0] w;
      w = root_weight(COMP_IDX_W'(k & (k ^ m)));
      if (m != 0) begin
         w = w << 1;
      end
      return w;
   endfunction

endpackage

/* rtl/multiquadratic_sq_distance_test_top.sv */
// -----------------------------------------------------------------------------
// multiquadratic_sq_distance_test_top
// Squares the difference of two points over the basis 1,3,11,33,35,105,385,
// 1155 and flags a match against a programmed rational target.
//
//   port group   direction  handshake          payload
//   req_*        in         valid / stall      a/b x/y packed coefficients
//   rsp_*        out        valid / stall      eight components + match flag
//   csr_*        in/out     APB style, 2 regs  target_square, checked_components
//
// One request per cycle sustained while the output is not stalled, through the six
// register stages (difference, products, weighting, two adder levels, output).
// Reset clears the stage valid bits and loads the register defaults.
// A stalled output freezes the whole pipeline; req_stall follows at once.
// -----------------------------------------------------------------------------
module multiquadratic_sq_distance_test_top #(
   parameter int COEF_BITS = mqsd_pkg::COEF_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  mqsd_pkg::req_payload_type          req_payload,
   // result channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output mqsd_pkg::rsp_payload_type          rsp_payload,
   // configuration port
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [mqsd_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [mqsd_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [mqsd_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready
);

   localparam int N      = mqsd_pkg::NUM_COMPONENTS;
   localparam int DIFF_W = COEF_BITS + 1;
   localparam int PROD_W = 2 * DIFF_W;
   localparam int PAIR_W = PROD_W + 1;
   localparam int TERM_W = PAIR_W + mqsd_pkg::WEIGHT_W;
   localparam int ACC_W  = mqsd_pkg::ACC_W;
   localparam int STAGES = 6;
   localparam int HALF   = N / 2;

   // ---------------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------------
   logic [ACC_W-1:0]             target_ff, target_in;
   logic [mqsd_pkg::CHECK_W-1:0] checked_ff, checked_in;
   logic                         csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Decode the write
   always_comb begin
      target_in  = target_ff;
      checked_in = checked_ff;
      if (csr_write) begin
         unique case (csr_paddr[2])
            mqsd_pkg::REG_TARGET:  target_in  = csr_pwdata;
            mqsd_pkg::REG_CHECKED: checked_in = csr_pwdata[mqsd_pkg::CHECK_W-1:0];
         endcase
      end
   end

   // Return the selected register
   always_comb begin
      unique case (csr_paddr[2])
         mqsd_pkg::REG_TARGET:  csr_prdata = target_ff;
         mqsd_pkg::REG_CHECKED: csr_prdata = mqsd_pkg::CSR_DATA_W'(checked_ff);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff  <= mqsd_pkg::TARGET_RESET;
         checked_ff <= mqsd_pkg::CHECKED_RESET;
      end else begin
         target_ff  <= target_in;
         checked_ff <= checked_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Pipeline control: the whole pipe advances unless the output is stalled
   // ---------------------------------------------------------------------------
   logic              advance;
   logic [STAGES-1:0] valid_ff, valid_in;

   assign advance   = !(valid_ff[STAGES-1] && rsp_stall);
   assign req_stall = !advance;
   assign rsp_valid = valid_ff[STAGES-1];
   assign valid_in  = {valid_ff[STAGES-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 1: coefficient differences B - A
   // ---------------------------------------------------------------------------
   logic signed [DIFF_W-1:0] dx_ff [N];
   logic signed [DIFF_W-1:0] dy_ff [N];
   logic signed [DIFF_W-1:0] dx_in [N];
   logic signed [DIFF_W-1:0] dy_in [N];

   always_comb begin
      for (int k = 0; k < N; k++) begin
         dx_in[k] = DIFF_W'(signed'(req_payload.b_x_packed[k*COEF_BITS +: COEF_BITS]))
                  - DIFF_W'(signed'(req_payload.a_x_packed[k*COEF_BITS +: COEF_BITS]));
         dy_in[k] = DIFF_W'(signed'(req_payload.b_y_packed[k*COEF_BITS +: COEF_BITS]))
                  - DIFF_W'(signed'(req_payload.a_y_packed[k*COEF_BITS +: COEF_BITS]));
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 2: products dx[k]*dx[k^m] + dy[k]*dy[k^m], one per distinct pair
   // ---------------------------------------------------------------------------
   logic signed [PAIR_W-1:0] pair_ff [N][N];
   logic signed [PAIR_W-1:0] pair_in [N][N];

   // ---------------------------------------------------------------------------
   // Stage 3: scale each pair by its root weight
   // ---------------------------------------------------------------------------
   logic signed [TERM_W-1:0] term_ff [N][N];
   logic signed [TERM_W-1:0] term_in [N][N];

   for (genvar m = 0; m < N; m++) begin : g_comp
      for (genvar k = 0; k < N; k++) begin : g_term
         localparam int J = k ^ m;
         localparam logic [mqsd_pkg::WEIGHT_W-2:0] WGT = mqsd_pkg::term_weight(m, k);
         if ((m == 0) || (k < J)) begin : g_used
            assign pair_in[m][k] = PAIR_W'(PROD_W'(dx_ff[k]) * PROD_W'(dx_ff[J]))
                                 + PAIR_W'(PROD_W'(dy_ff[k]) * PROD_W'(dy_ff[J]));
            assign term_in[m][k] = TERM_W'(pair_ff[m][k])
                                 * TERM_W'(signed'({1'b0, WGT}));
         end else begin : g_mirror
            // mirrored pair folded into the doubled weight of its partner
            assign pair_in[m][k] = '0;
            assign term_in[m][k] = '0;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 4: two partial sums of four terms per component
   // ---------------------------------------------------------------------------
   logic signed [ACC_W-1:0] half_ff [N][2];
   logic signed [ACC_W-1:0] half_in [N][2];

   always_comb begin
      for (int m = 0; m < N; m++) begin
         for (int h = 0; h < 2; h++) begin
            half_in[m][h] = ACC_W'(term_ff[m][h*HALF])
                          + ACC_W'(term_ff[m][h*HALF+1])
                          + ACC_W'(term_ff[m][h*HALF+2])
                          + ACC_W'(term_ff[m][h*HALF+3]);
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 5: full components
   // ---------------------------------------------------------------------------
   logic signed [ACC_W-1:0] acc_ff [N];
   logic signed [ACC_W-1:0] acc_in [N];

   always_comb begin
      for (int m = 0; m < N; m++) begin
         acc_in[m] = half_ff[m][0] + half_ff[m][1];
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 6: match test and output register
   // ---------------------------------------------------------------------------
   logic [mqsd_pkg::CHECK_W-1:0] checked_eff;
   logic                         match;
   mqsd_pkg::rsp_payload_type    rsp_ff, rsp_in;

   // Clamp the compared count into 1..8
   always_comb begin
      checked_eff = checked_ff;
      if (checked_ff < mqsd_pkg::CHECKED_MIN) begin
         checked_eff = mqsd_pkg::CHECKED_MIN;
      end else if (checked_ff > mqsd_pkg::CHECKED_MAX) begin
         checked_eff = mqsd_pkg::CHECKED_MAX;
      end
   end

   // Component 0 is never negative, so a bitwise compare with the target holds
   always_comb begin
      match = ($unsigned(acc_ff[0]) == target_ff);
      for (int k = 1; k < N; k++) begin
         if ((mqsd_pkg::CHECK_W'(k) < checked_eff) && (acc_ff[k] != '0)) begin
            match = 1'b0;
         end
      end
   end

   always_comb begin
      rsp_in.sq_comp0 = acc_ff[0];
      rsp_in.sq_comp1 = acc_ff[1];
      rsp_in.sq_comp2 = acc_ff[2];
      rsp_in.sq_comp3 = acc_ff[3];
      rsp_in.sq_comp4 = acc_ff[4];
      rsp_in.sq_comp5 = acc_ff[5];
      rsp_in.sq_comp6 = acc_ff[6];
      rsp_in.sq_comp7 = acc_ff[7];
      rsp_in.is_match = match;
   end

   assign rsp_payload = rsp_ff;

   // Advance the data stages together with their valid bits
   always_ff @(posedge clock) begin
      if (advance) begin
         dx_ff   <= dx_in;
         dy_ff   <= dy_in;
         pair_ff <= pair_in;
         term_ff <= term_in;
         half_ff <= half_in;
         acc_ff  <= acc_in;
         rsp_ff  <= rsp_in;
      end
   end

endmodule

/* rtl/mqsd_checker.sv */
// -----------------------------------------------------------------------------
// mqsd_checker
// Port-level checks for the squared distance test, bound to the top level.
// -----------------------------------------------------------------------------
module mqsd_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_stall,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input mqsd_pkg::rsp_payload_type  rsp_payload
);

   // Hold a stalled result
   a_rsp_valid_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_payload_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> $stable(rsp_payload))
      else $error("stalled result changed");

   // Block new requests while the output is stalled
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> req_stall)
      else $error("request taken while output stalled");

   // Rational component of a squared length is never negative
   a_comp0_nonneg: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_payload.sq_comp0[mqsd_pkg::ACC_W-1])
      else $error("negative rational component");

   // Come out of reset with nothing to deliver
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind multiquadratic_sq_distance_test_top mqsd_checker u_mqsd_checker (.*);

/* tb/multiquadratic_sq_distance_test_checker.sv */
// -----------------------------------------------------------------------------
// multiquadratic_sq_distance_test_checker
// Watches the request, result and register ports of the squared distance
// test block. It keeps its own copy of the two registers, works out the
// squared length and match flag of every accepted request, and compares each
// accepted result field by field with the oldest pending prediction.
// -----------------------------------------------------------------------------
module multiquadratic_sq_distance_test_checker
   import mqsd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  req_payload_type       req_payload,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  rsp_payload_type       rsp_payload,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   input  logic [CSR_DATA_W-1:0] csr_prdata,
   input  logic                  csr_pready,
   output int                    mismatch_count,
   output int                    pending_count,
   output int                    result_count,
   output int                    match_count
);

   localparam int COEF_BITS   = COEF_BITS_DEF;
   localparam int PRINT_LIMIT = 100;
   localparam int ROOT [NUM_COMPONENTS] = '{1, 3, 11, 33, 35, 105, 385, 1155};

   typedef logic signed [ACC_W-1:0] comp_row_type [NUM_COMPONENTS];

   logic [ACC_W-1:0]   target_cfg;
   logic [CHECK_W-1:0] checked_cfg;
   rsp_payload_type    squares_q [$];

   initial begin
      mismatch_count = 0;
      pending_count  = 0;
      result_count   = 0;
      match_count    = 0;
   end

   // Print one line per mismatch (up to a cap) and count it
   task automatic report_mismatch(input string what, input longint got, input longint want);
      if (mismatch_count < PRINT_LIMIT) begin
         $display("ERROR %s: got %0d, expected %0d", what, got, want);
      end
      mismatch_count++;
   endtask

   function automatic int lane_coef(input logic [PACKED_W-1:0] v, input int k);
      return int'($signed(v[k*COEF_BITS +: COEF_BITS]));
   endfunction

   // Square B - A per coordinate in the multiquadratic field and test the target
   function automatic rsp_payload_type predict_square(input req_payload_type p);
      int     dx [NUM_COMPONENTS];
      int     dy [NUM_COMPONENTS];
      longint acc [NUM_COMPONENTS];
      int     span;
      logic   hit;
      for (int k = 0; k < NUM_COMPONENTS; k++) begin
         dx[k]  = lane_coef(p.b_x_packed, k) - lane_coef(p.a_x_packed, k);
         dy[k]  = lane_coef(p.b_y_packed, k) - lane_coef(p.a_y_packed, k);
         acc[k] = 0;
      end
      for (int i = 0; i < NUM_COMPONENTS; i++) begin
         for (int j = 0; j < NUM_COMPONENTS; j++) begin
            acc[i ^ j] += longint'(dx[i] * dx[j] + dy[i] * dy[j]) * ROOT[i & j];
         end
      end
      // Clamp the compared count into 1..8
      span = int'(checked_cfg);
      if (span < 1) begin
         span = 1;
      end
      if (span > NUM_COMPONENTS) begin
         span = NUM_COMPONENTS;
      end
      hit = (acc[0] == longint'(target_cfg));
      for (int k = 1; k < span; k++) begin
         if (acc[k] != 0) begin
            hit = 1'b0;
         end
      end
      return '{32'(acc[0]), 32'(acc[1]), 32'(acc[2]), 32'(acc[3]),
               32'(acc[4]), 32'(acc[5]), 32'(acc[6]), 32'(acc[7]), hit};
   endfunction

   function automatic comp_row_type comp_row(input rsp_payload_type r);
      return '{r.sq_comp0, r.sq_comp1, r.sq_comp2, r.sq_comp3,
               r.sq_comp4, r.sq_comp5, r.sq_comp6, r.sq_comp7};
   endfunction

   always @(posedge clock) begin
      rsp_payload_type  want;
      comp_row_type     got_row;
      comp_row_type     want_row;
      logic [CSR_DATA_W-1:0] reg_value;
      if (reset) begin
         squares_q.delete();
         target_cfg  = TARGET_RESET;
         checked_cfg = CHECKED_RESET;
      end else begin
         // Track register writes and check read data
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_paddr[CSR_ADDR_W-1] == REG_TARGET) begin
               reg_value = target_cfg;
            end else begin
               reg_value = CSR_DATA_W'(checked_cfg);
            end
            if (csr_pwrite) begin
               if (csr_paddr[CSR_ADDR_W-1] == REG_TARGET) begin
                  target_cfg = csr_pwdata;
               end else begin
                  checked_cfg = csr_pwdata[CHECK_W-1:0];
               end
            end else if (csr_prdata !== reg_value) begin
               report_mismatch($sformatf("register read at %0d", csr_paddr),
                               csr_prdata, reg_value);
            end
         end
         // Predict each accepted request
         if (req_valid && !req_stall) begin
            squares_q.push_back(predict_square(req_payload));
         end
         // Compare each accepted result with the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            result_count++;
            if (squares_q.size() == 0) begin
               report_mismatch("result with no request pending", 1, 0);
            end else begin
               want     = squares_q.pop_front();
               got_row  = comp_row(rsp_payload);
               want_row = comp_row(want);
               for (int k = 0; k < NUM_COMPONENTS; k++) begin
                  if (got_row[k] !== want_row[k]) begin
                     report_mismatch($sformatf("sq_comp%0d", k), got_row[k], want_row[k]);
                  end
               end
               if (rsp_payload.is_match !== want.is_match) begin
                  report_mismatch("is_match", rsp_payload.is_match, want.is_match);
               end
               if (want.is_match) begin
                  match_count++;
               end
            end
         end
      end
      pending_count = squares_q.size();
   end

endmodule

/* tb/multiquadratic_sq_distance_test_top_test.sv */
// -----------------------------------------------------------------------------
// multiquadratic_sq_distance_test_top_test
// Drives the squared distance test block with directed point pairs, then
// with phases of random requests under changing target and component count
// settings. Most random requests share the difference vector of the phase
// (offset, negated, swapped) so matches occur; the rest are noise or hits
// with one bit broken. The checker beside the block does the comparing.
// -----------------------------------------------------------------------------
module multiquadratic_sq_distance_test_top_test;
   import mqsd_pkg::*;

   localparam int NUM_PHASES   = 13;
   localparam int PHASE_ITEMS  = 105;
   localparam int IDLE_LIMIT   = 3000;
   localparam int DRAIN_CYCLES = 24;
   localparam int HOLD_OFF     = 100;
   localparam int ROOT [NUM_COMPONENTS] = '{1, 3, 11, 33, 35, 105, 385, 1155};
   localparam logic [CHECK_W-1:0] CHECKED_LIST [NUM_PHASES] =
      '{4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd15, 4'd12, 4'd8, 4'd1};

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_payload_type       req_payload;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_payload_type       rsp_payload;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int mismatch_count;
   int pending_count;
   int result_count;
   int match_count;
   int sent_count;
   int idle_cycles;
   bit sender_quiet;
   int seed_dx [NUM_COMPONENTS];
   int seed_dy [NUM_COMPONENTS];

   multiquadratic_sq_distance_test_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   multiquadratic_sq_distance_test_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_payload    (rsp_payload),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count),
      .result_count   (result_count),
      .match_count    (match_count)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // End the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_psel && csr_penable)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Offer one request after a drawn gap; hold it until accepted
   task automatic send_request(input req_payload_type p);
      int gap;
      gap = sender_quiet ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_payload <= p;
      req_valid   <= 1'b1;
      do @(posedge clock); while (req_stall);
      sent_count++;
      @(negedge clock);
   endtask

   // One register access: setup cycle, then access cycle
   task automatic csr_access(input logic write, input logic idx,
                             input logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   // Drop valid and wait until every request has its result
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
   endtask

   // Random base point plus a difference, lanes kept in 8-bit range
   function automatic void make_pair(input int diff [NUM_COMPONENTS],
                                     output logic [PACKED_W-1:0] a,
                                     output logic [PACKED_W-1:0] b);
      int d, lo, hi, av;
      bit neg, swap;
      neg  = $urandom_range(0, 1);
      swap = $urandom_range(0, 1);
      for (int k = 0; k < NUM_COMPONENTS; k++) begin
         d  = neg ? -diff[k] : diff[k];
         lo = (d < 0) ? -128 - d : -128;
         hi = (d > 0) ? 127 - d : 127;
         av = lo + int'($urandom_range(0, hi - lo));
         a[k*COEF_BITS_DEF +: COEF_BITS_DEF] = COEF_BITS_DEF'(av);
         b[k*COEF_BITS_DEF +: COEF_BITS_DEF] = COEF_BITS_DEF'(av + d);
      end
      if (swap) begin
         {a, b} = {b, a};
      end
   endfunction

   // Request with the phase difference vectors, shuffled between x and y
   function automatic req_payload_type seeded_request();
      req_payload_type p;
      logic [PACKED_W-1:0] ax, bx, ay, by;
      if ($urandom_range(0, 1)) begin
         make_pair(seed_dx, ax, bx);
         make_pair(seed_dy, ay, by);
      end else begin
         make_pair(seed_dy, ax, bx);
         make_pair(seed_dx, ay, by);
      end
      p = '{ax, ay, bx, by};
      return p;
   endfunction

   // Receiver: drawn stalls, quiet stretches, and two long hold-offs
   initial begin
      int hold;
      int taken;
      taken = 0;
      wait (reset == 1'b0);
      @(negedge clock);
      forever begin
         if (taken == 200 || taken == 800) begin
            hold = HOLD_OFF;
         end else if ((taken / 60) % 2 == 1) begin
            hold = 0;
         end else begin
            hold = $urandom_range(0, 9);
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!rsp_valid);
         taken++;
         @(negedge clock);
      end
   end

   initial begin
      req_payload_type item;
      logic [ACC_W-1:0] target;
      int kind;
      int bit_idx;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_payload  = '0;
      rsp_stall    = 1'b0;
      csr_psel     = 1'b0;
      csr_penable  = 1'b0;
      csr_pwrite   = 1'b0;
      csr_paddr    = '0;
      csr_pwdata   = '0;
      idle_cycles  = 0;
      sent_count   = 0;
      sender_quiet = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Check register reset values
      csr_access(1'b0, REG_TARGET, '0);
      csr_access(1'b0, REG_CHECKED, '0);

      // Directed requests under reset settings (target 3600, four components)
      send_request(req_payload_type'{64'd0, 64'd0, 64'd0, 64'd0});
      send_request(req_payload_type'{64'd0, 64'd0, 64'd60, 64'd0});
      send_request(req_payload_type'{64'd60, 64'd0, 64'd0, 64'd0});
      send_request(req_payload_type'{64'hC4, 64'd0, 64'd0, 64'd0});
      send_request(req_payload_type'{64'd0, 64'd0, 64'd36, 64'd48});
      send_request(req_payload_type'{{8{8'h80}}, {8{8'h80}}, {8{8'h7F}}, {8{8'h7F}}});
      send_request(req_payload_type'{{8{8'h7F}}, {8{8'h7F}}, {8{8'h80}}, {8{8'h80}}});
      send_request(req_payload_type'{{8{8'hFF}}, {8{8'hFF}}, {8{8'h01}}, {8{8'h01}}});
      send_request(req_payload_type'{64'd0, 64'd0, {8{8'h80}}, {8{8'h7F}}});
      // rational part hits the target, but an unchecked component is nonzero
      send_request(req_payload_type'{64'd0, 64'd0, 64'h0000_000A_0000_000A, 64'd0});
      // rational part hits the target, but a checked component is nonzero
      send_request(req_payload_type'{64'd0, 64'd0, 64'h1E1E, 64'd0});
      // single lanes pick up each root weight
      for (int k = 0; k < NUM_COMPONENTS; k++) begin
         send_request(req_payload_type'{64'd0, 64'd0, 64'h01 << (8 * k),
                                         64'hFF << (8 * (7 - k))});
      end

      // Random phases, one register setting each
      for (int p = 0; p < NUM_PHASES; p++) begin
         wait_drained();
         for (int k = 0; k < NUM_COMPONENTS; k++) begin
            seed_dx[k] = ($urandom_range(0, 2) == 0) ? int'($urandom_range(0, 510)) - 255 : 0;
            seed_dy[k] = ($urandom_range(0, 2) == 0) ? int'($urandom_range(0, 510)) - 255 : 0;
            if (p == 2) begin
               seed_dx[k] = 0;
               seed_dy[k] = 0;
            end
         end
         target = '0;
         for (int k = 0; k < NUM_COMPONENTS; k++) begin
            target += ACC_W'((seed_dx[k] * seed_dx[k] + seed_dy[k] * seed_dy[k]) * ROOT[k]);
         end
         if (p == 6) begin
            target = '1;
         end
         csr_access(1'b1, REG_TARGET, target);
         csr_access(1'b1, REG_CHECKED, CSR_DATA_W'(CHECKED_LIST[p]));
         csr_access(1'b0, REG_TARGET, '0);
         csr_access(1'b0, REG_CHECKED, '0);
         sender_quiet = (p % 3 == 1);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            kind = $urandom_range(0, 9);
            if (kind < 6) begin
               item = seeded_request();
            end else if (kind < 9) begin
               item = {$urandom(), $urandom(), $urandom(), $urandom(),
                       $urandom(), $urandom(), $urandom(), $urandom()};
            end else begin
               // break a hit by flipping one bit
               item = seeded_request();
               bit_idx = $urandom_range(0, $bits(req_payload_type) - 1);
               item[bit_idx] = ~item[bit_idx];
            end
            send_request(item);
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("Sent %0d requests and checked %0d results, %0d of them matches,",
               sent_count, result_count, match_count);
      $display("over %0d register settings with component counts 0 to 15.",
               NUM_PHASES + 1);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
